/* sv/rme_pkg.sv */
package rme_pkg;

    localparam int DW = 32;
    localparam int MAX_STEPS = 24;
    localparam int PRE_SHIFT = 8;
    localparam logic signed [16:0] INV_GAIN = 17'sd39797;
    localparam logic [31:0] HALF_TURN = 32'h8000_0000;
    localparam logic [31:0] ROUND_HALF = 32'h0000_8000;

    localparam logic [31:0] ATAN_TAB [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    function automatic logic [15:0] to_angle(input logic [31:0] z);
        logic [31:0] t;
        t = z + ROUND_HALF;
        return t[31:16];
    endfunction

endpackage

/* sv/rotation_matrix_to_euler.sv */
// Converts a rotation matrix (seven Q1.14 entries) to yaw, pitch and roll as
// 16-bit binary angles, 32768 codes per half turn, +pi and -pi both -32768.
// Takes one word per cycle while not stalled; a word passes through an input
// register, the yaw CORDIC row, a gain-multiply register, a pre-rotation
// register, the pitch and roll CORDIC rows (one cell per step) and an output
// register. The whole pipeline stalls while a result waits on out_ready.
module rotation_matrix_to_euler #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] m00,
    input  logic signed [15:0] m01,
    input  logic signed [15:0] m02,
    input  logic signed [15:0] m10,
    input  logic signed [15:0] m11,
    input  logic signed [15:0] m12,
    input  logic signed [15:0] m20,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] yaw_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] roll_angle
);

    localparam int DW = rme_pkg::DW;
    localparam int S = (CORDIC_STEPS < rme_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                           : rme_pkg::MAX_STEPS;
    localparam int L = 2 * S + 4;

    logic [L-1:0] vld_reg;
    logic         adv;

    assign adv       = !vld_reg[L-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[L-2:0], in_valid};
    end

    // input stage: scale and pre-rotate the yaw vectors
    logic signed [DW-1:0] a_x [3];
    logic signed [DW-1:0] a_y [3];
    logic signed [DW-1:0] yx [S+1][3];
    logic signed [DW-1:0] yy [S+1][3];
    logic        [31:0]   yz [S+1];
    logic                 yact [S+1];
    logic signed [DW-1:0] m20_reg [S+1];

    always_comb
    begin
        a_x[0] = DW'(m00) <<< rme_pkg::PRE_SHIFT;
        a_y[0] = DW'(m10) <<< rme_pkg::PRE_SHIFT;
        a_x[1] = DW'(m01) <<< rme_pkg::PRE_SHIFT;
        a_y[1] = DW'(m11) <<< rme_pkg::PRE_SHIFT;
        a_x[2] = DW'(m02) <<< rme_pkg::PRE_SHIFT;
        a_y[2] = DW'(m12) <<< rme_pkg::PRE_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                yx[0][k] <= (m00 < 0) ? -a_x[k] : a_x[k];
                yy[0][k] <= (m00 < 0) ? -a_y[k] : a_y[k];
            end
            yz[0]      <= (m00 < 0) ? rme_pkg::HALF_TURN : '0;
            yact[0]    <= (m00 != 0) || (m10 != 0);
            m20_reg[0] <= DW'(m20) <<< rme_pkg::PRE_SHIFT;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_yaw
        rme_cell #(.STEP(i), .NVEC(3)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .act_in (yact[i]),
            .x_in   (yx[i]),
            .y_in   (yy[i]),
            .z_in   (yz[i]),
            .act_reg(yact[i+1]),
            .x_reg  (yx[i+1]),
            .y_reg  (yy[i+1]),
            .z_reg  (yz[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                m20_reg[i+1] <= m20_reg[i];
        end
    end

    // gain stage: scale pitch denominator, form roll operands
    logic signed [48:0]   prod;
    logic signed [DW-1:0] b_px_reg, b_py_reg, b_rx_reg, b_ry_reg;
    logic        [15:0]   b_yaw_reg;

    assign prod = yx[S][0] * rme_pkg::INV_GAIN;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_px_reg  <= prod[47:16];
            b_py_reg  <= -m20_reg[S];
            b_rx_reg  <= yy[S][1];
            b_ry_reg  <= -yy[S][2];
            b_yaw_reg <= yact[S] ? rme_pkg::to_angle(yz[S]) : '0;
        end
    end

    // pre-rotation of pitch and roll
    logic signed [DW-1:0] px [S+1][1];
    logic signed [DW-1:0] py [S+1][1];
    logic        [31:0]   pz [S+1];
    logic                 pact [S+1];
    logic signed [DW-1:0] rx [S+1][1];
    logic signed [DW-1:0] ry [S+1][1];
    logic        [31:0]   rz [S+1];
    logic                 ract [S+1];
    logic        [15:0]   yaw_pipe [S+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px[0][0]    <= (b_px_reg < 0) ? -b_px_reg : b_px_reg;
            py[0][0]    <= (b_px_reg < 0) ? -b_py_reg : b_py_reg;
            pz[0]       <= (b_px_reg < 0) ? rme_pkg::HALF_TURN : '0;
            pact[0]     <= (b_px_reg != 0) || (b_py_reg != 0);
            rx[0][0]    <= (b_rx_reg < 0) ? -b_rx_reg : b_rx_reg;
            ry[0][0]    <= (b_rx_reg < 0) ? -b_ry_reg : b_ry_reg;
            rz[0]       <= (b_rx_reg < 0) ? rme_pkg::HALF_TURN : '0;
            ract[0]     <= (b_rx_reg != 0) || (b_ry_reg != 0);
            yaw_pipe[0] <= b_yaw_reg;
        end
    end

    for (genvar i = 0; i < S; i++)
    begin : g_pr
        rme_cell #(.STEP(i), .NVEC(1)) u_pitch (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .act_in (pact[i]),
            .x_in   (px[i]),
            .y_in   (py[i]),
            .z_in   (pz[i]),
            .act_reg(pact[i+1]),
            .x_reg  (px[i+1]),
            .y_reg  (py[i+1]),
            .z_reg  (pz[i+1])
        );

        rme_cell #(.STEP(i), .NVEC(1)) u_roll (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .act_in (ract[i]),
            .x_in   (rx[i]),
            .y_in   (ry[i]),
            .z_in   (rz[i]),
            .act_reg(ract[i+1]),
            .x_reg  (rx[i+1]),
            .y_reg  (ry[i+1]),
            .z_reg  (rz[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
                yaw_pipe[i+1] <= yaw_pipe[i];
        end
    end

    // output register
    logic [15:0] yaw_reg, pitch_reg, roll_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yaw_reg   <= yaw_pipe[S];
            pitch_reg <= pact[S] ? rme_pkg::to_angle(pz[S]) : '0;
            roll_reg  <= ract[S] ? rme_pkg::to_angle(rz[S]) : '0;
        end
    end

    assign yaw_angle   = yaw_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready does not follow output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(yaw_angle)
            && $stable(pitch_angle) && $stable(roll_angle)))
        else $error("stalled word lost or changed");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && !in_valid) |=> !vld_reg[0])
        else $error("pipeline took a word that was not offered");

    a_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[L-2]) |=> out_valid)
        else $error("word dropped at output stage");

endmodule

/* sv/rme_cell.sv */
module rme_cell #(
    parameter int STEP = 0,
    parameter int NVEC = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          act_in,
    input  logic signed [rme_pkg::DW-1:0] x_in [NVEC],
    input  logic signed [rme_pkg::DW-1:0] y_in [NVEC],
    input  logic        [31:0]            z_in,
    output logic                          act_reg,
    output logic signed [rme_pkg::DW-1:0] x_reg [NVEC],
    output logic signed [rme_pkg::DW-1:0] y_reg [NVEC],
    output logic        [31:0]            z_reg
);

    localparam logic [31:0] ATAN = rme_pkg::ATAN_TAB[STEP];

    logic signed [rme_pkg::DW-1:0] x_next [NVEC];
    logic signed [rme_pkg::DW-1:0] y_next [NVEC];
    logic        [31:0]            z_next;
    logic                          d;

    always_comb
    begin
        d = (y_in[0] >= 0);
        for (int k = 0; k < NVEC; k++)
        begin
            if (!act_in)
            begin
                x_next[k] = x_in[k];
                y_next[k] = y_in[k];
            end
            else if (d)
            begin
                x_next[k] = x_in[k] + (y_in[k] >>> STEP);
                y_next[k] = y_in[k] - (x_in[k] >>> STEP);
            end
            else
            begin
                x_next[k] = x_in[k] - (y_in[k] >>> STEP);
                y_next[k] = y_in[k] + (x_in[k] >>> STEP);
            end
        end
        if (!act_in)
            z_next = z_in;
        else if (d)
            z_next = z_in + ATAN;
        else
            z_next = z_in - ATAN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= 1'b0;
        else if (adv)
            act_reg <= act_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule
